// ===== sv/dwmc_pkg.sv =====
// shared constants and types for the delimited word match counter
package dwmc_pkg;

    localparam int MAX_WORD_CHARS_DEF = 8;
    localparam int COUNT_BITS_DEF     = 16;

    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 4;
    localparam int FIELD_W   = 16;
    localparam int OUT_CNT_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] FIELD_SEP = 8'h2C;

    localparam logic [1:0] FIRST_A    = 2'd0;
    localparam logic [1:0] FIRST_B    = 2'd1;
    localparam logic [1:0] FIRST_NONE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_A_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_A_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_B_CHARS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_B_LENGTH = 2'd3;

    typedef struct packed {
        logic advance;
        logic take;
        logic sep;
        logic last;
    } dwmc_ctl_t;

    typedef struct packed {
        logic                 found;
        logic [FIELD_W-1:0]   first_field;
        logic [OUT_CNT_W-1:0] count;
    } dwmc_status_t;

endpackage

// ===== sv/dwmc_char_if.sv =====
// character and result channel interfaces
interface dwmc_char_if
    import dwmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              line_end;

    modport source (output valid, output char_code, output char_present, output line_end,
                    input ready);
    modport sink (input valid, input char_code, input char_present, input line_end,
                  output ready);
endinterface

interface dwmc_result_if
    import dwmc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           first_word;
    logic [OUT_CNT_W-1:0] count_a;
    logic [OUT_CNT_W-1:0] count_b;

    modport source (output valid, output first_word, output count_a, output count_b,
                    input ready);
    modport sink (input valid, input first_word, input count_a, input count_b,
                  output ready);
endinterface

// ===== sv/dwmc_word_track.sv =====
// per-word field match tracking: running match flag, tally and first match field
module dwmc_word_track
    import dwmc_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WORD_W-1:0]   word_chars,
    input  logic [LEN_W-1:0]    word_length,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [POS_W-1:0]    char_pos,
    input  logic [FIELD_W-1:0]  field_number,
    input  dwmc_ctl_t           ctl,
    output dwmc_status_t        status
);

    localparam logic [LEN_W-1:0]      MAX_LEN   = LEN_W'(MAX_WORD_CHARS);
    localparam logic [POS_W-1:0]      POS_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    logic                  still_reg;
    logic [COUNT_BITS-1:0] tally_reg;
    logic [COUNT_BITS-1:0] tally_next;
    logic                  found_reg;
    logic                  found_next;
    logic [FIELD_W-1:0]    first_reg;
    logic [FIELD_W-1:0]    first_next;

    logic             pos_ok;
    logic             len_ok;
    logic [7:0]       word_byte;
    logic [POS_W-1:0] pos_after;
    logic             still_after;
    logic             match;

    assign pos_ok      = (char_pos < word_length) && (char_pos < MAX_LEN);
    assign len_ok      = (word_length != '0) && (word_length <= MAX_LEN);
    assign word_byte   = word_chars[8*char_pos[2:0] +: 8];
    assign pos_after   = (char_pos == POS_MAX) ? POS_MAX : char_pos + 1'b1;
    assign still_after = still_reg && pos_ok && (word_byte == char_code);

    always_comb
    begin
        match = 1'b0;
        if (len_ok)
        begin
            if (ctl.sep)
                match = still_reg && (char_pos == word_length);
            else if (ctl.last && ctl.take)
                match = still_after && (pos_after == word_length);
            else if (ctl.last)
                match = still_reg && (char_pos == word_length);
        end
    end

    assign tally_next = (match && (tally_reg != TALLY_MAX)) ? tally_reg + 1'b1 : tally_reg;
    assign found_next = found_reg || match;
    assign first_next = (match && !found_reg) ? field_number : first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_reg <= 1'b1;
            tally_reg <= '0;
            found_reg <= 1'b0;
            first_reg <= '0;
        end
        else if (ctl.advance)
        begin
            if (ctl.last)
            begin
                still_reg <= 1'b1;
                tally_reg <= '0;
                found_reg <= 1'b0;
                first_reg <= '0;
            end
            else
            begin
                if (ctl.sep)
                    still_reg <= 1'b1;
                else if (ctl.take)
                    still_reg <= still_after;
                tally_reg <= tally_next;
                found_reg <= found_next;
                first_reg <= first_next;
            end
        end
    end

    assign status.found       = found_next;
    assign status.first_field = first_next;

    generate
        if (COUNT_BITS > OUT_CNT_W)
        begin : g_clamp
            assign status.count = (|tally_next[COUNT_BITS-1:OUT_CNT_W]) ? '1
                                  : tally_next[OUT_CNT_W-1:0];
        end
        else
        begin : g_extend
            assign status.count = OUT_CNT_W'(tally_next);
        end
    endgenerate

endmodule

// ===== sv/delimited_word_match_counter.sv =====
// top level of the delimited word match counter
// Takes one comma separated line, one character per transfer, and counts the fields that
// equal configured word A and word B exactly (case-sensitive). The transfer that carries
// line_end produces one result: which word matched in the earlier field (0 A, 1 B,
// 2 neither or a tie) and both counts, after which line state clears. A transfer with
// a character and line_end applies the character first. One character is accepted
// every cycle: each transfer passes straight on from the input register and the result
// register frees as soon as its result is taken, so only a held result with a pending
// line end stalls input. The result is registered behind the input register. Write the
// word registers only while the block is idle.
module delimited_word_match_counter
    import dwmc_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dwmc_char_if.sink            char_in,
    dwmc_result_if.source        result_out,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    logic [WORD_W-1:0] word_a_chars_reg;
    logic [LEN_W-1:0]  word_a_length_reg;
    logic [WORD_W-1:0] word_b_chars_reg;
    logic [LEN_W-1:0]  word_b_length_reg;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              present_reg;
    logic              last_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [FIELD_W-1:0] field_reg;

    logic                 out_valid_reg;
    logic [1:0]           first_word_reg;
    logic [OUT_CNT_W-1:0] count_a_reg;
    logic [OUT_CNT_W-1:0] count_b_reg;
    logic [1:0]           first_word_next;

    logic         out_free;
    dwmc_ctl_t    ctl;
    dwmc_status_t status_a;
    dwmc_status_t status_b;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_chars_reg  <= '0;
            word_a_length_reg <= LEN_W'(1);
            word_b_chars_reg  <= '0;
            word_b_length_reg <= LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WORD_A_CHARS:  word_a_chars_reg  <= cfg_data;
                CFG_WORD_A_LENGTH: word_a_length_reg <= cfg_data[LEN_W-1:0];
                CFG_WORD_B_CHARS:  word_b_chars_reg  <= cfg_data;
                CFG_WORD_B_LENGTH: word_b_length_reg <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // handshake
    assign out_free    = !out_valid_reg || result_out.ready;
    assign ctl.advance = in_valid_reg && (!last_reg || out_free);
    assign ctl.take    = present_reg && (char_reg != FIELD_SEP);
    assign ctl.sep     = present_reg && (char_reg == FIELD_SEP);
    assign ctl.last    = last_reg;
    assign char_in.ready = !in_valid_reg || ctl.advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_in.ready)
            in_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            char_reg    <= char_in.char_code;
            present_reg <= char_in.char_present;
            last_reg    <= char_in.line_end;
        end
    end

    // field position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            field_reg <= '0;
        end
        else if (ctl.advance)
        begin
            priority if (ctl.last)
            begin
                pos_reg   <= '0;
                field_reg <= '0;
            end
            else if (ctl.sep)
            begin
                pos_reg <= '0;
                if (field_reg != FIELD_MAX)
                    field_reg <= field_reg + 1'b1;
            end
            else if (ctl.take)
            begin
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 1'b1;
            end
            else
            begin
                pos_reg   <= pos_reg;
                field_reg <= field_reg;
            end
        end
    end

    dwmc_word_track #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_track_a (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_chars   (word_a_chars_reg),
        .word_length  (word_a_length_reg),
        .char_code    (char_reg),
        .char_pos     (pos_reg),
        .field_number (field_reg),
        .ctl          (ctl),
        .status       (status_a)
    );

    dwmc_word_track #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_track_b (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_chars   (word_b_chars_reg),
        .word_length  (word_b_length_reg),
        .char_code    (char_reg),
        .char_pos     (pos_reg),
        .field_number (field_reg),
        .ctl          (ctl),
        .status       (status_b)
    );

    always_comb
    begin
        priority if (status_a.found &&
                     (!status_b.found || (status_a.first_field < status_b.first_field)))
            first_word_next = FIRST_A;
        else if (status_b.found &&
                 (!status_a.found || (status_b.first_field < status_a.first_field)))
            first_word_next = FIRST_B;
        else
            first_word_next = FIRST_NONE;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.advance && ctl.last)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.last)
        begin
            first_word_reg <= first_word_next;
            count_a_reg    <= status_a.count;
            count_b_reg    <= status_b.count;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.first_word = first_word_reg;
    assign result_out.count_a    = count_a_reg;
    assign result_out.count_b    = count_b_reg;

    // checks
    a_first_a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (first_word_reg == FIRST_A) |-> count_a_reg != '0)
        else $error("word A reported first with zero count");

    a_first_b_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (first_word_reg == FIRST_B) |-> count_b_reg != '0)
        else $error("word B reported first with zero count");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance && ctl.last |=> (pos_reg == '0) && (field_reg == '0) && out_valid_reg)
        else $error("line end did not clear state or raise result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready |-> !(ctl.advance && ctl.last))
        else $error("held result overwritten");

endmodule
